@@ design/hht_pkg.sv @@
package hht_pkg;

    // Sizing of the slot table
    localparam int SLOTS      = 16;
    localparam int COUNT_BITS = 20;
    localparam int VALUE_BITS = 30;
    localparam int CFG_BITS   = 7;
    localparam int IDX_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENTRY_BITS = VALUE_BITS + COUNT_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [CFG_BITS-1:0]   SLOTS_IN_USE_RESET = CFG_BITS'(2);

    // Action codes
    localparam logic ACT_ELEMENT = 1'b0;
    localparam logic ACT_QUERY   = 1'b1;

endpackage

@@ design/heavy_hitter_tracker.sv @@
// Misra-Gries frequent-item tracker.
// Input channel (in_valid/in_ready) takes one word: action and item_value.
// An element word (action 0) updates the slot table and gives no output word.
// A query word (action 1) gives one candidate word per active slot on the
// output channel (out_valid/out_ready), in slot order, last high on the final one.
// The config channel (cfg_valid/cfg_ready) sets slots_in_use; write it only while idle.
// Element words scan the active slots in slot order and stop at a matching slot;
// an element that matches no slot claims the lowest free slot, and when all
// slots are busy a decrement sweep over the active slots follows instead.
// A query reads each candidate from the slot memory, then loads it into the output.
// The single slot memory allows one read and one write per cycle.
// One word is worked on at a time; in_ready is high only between words.
// The output register holds a candidate while out_ready is low, and the query
// pauses until it is taken; a new word may be accepted while the last waits.
// Reset clears all slots (per-slot valid bits), the fill count and the output,
// and sets slots_in_use to 2. No clearing sweep is needed.
module heavy_hitter_tracker
    import hht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_BITS-1:0]   slots_in_use,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic [VALUE_BITS-1:0] item_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [VALUE_BITS-1:0] candidate,
    output logic                  last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DEC,
        S_QRD,
        S_QOUT
    } state_t;

    state_t                state_reg, state_next;
    logic [CFG_BITS-1:0]   cfg_reg, cfg_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [IDX_BITS-1:0]   last_idx_reg, last_idx_next;
    logic [IDX_BITS-1:0]   ra_reg, ra_next;
    logic                  issuing_reg, issuing_next;
    logic                  chk_pend_reg, chk_pend_next;
    logic [IDX_BITS-1:0]   chk_idx_reg, chk_idx_next;
    logic                  have_free_reg, have_free_next;
    logic [IDX_BITS-1:0]   free_at_reg, free_at_next;
    logic [CFG_BITS-1:0]   filled_reg, filled_next;
    logic [SLOTS-1:0]      slot_ok_reg, slot_ok_next;
    logic                  rd_ok_reg, rd_ok_next;
    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] cand_reg, cand_next;
    logic                  last_reg, last_next;

    // Slot memory: value in the upper bits, count in the lower bits
    logic [ENTRY_BITS-1:0] mem [SLOTS];
    logic [ENTRY_BITS-1:0] rd_data_reg;
    logic                  mem_re;
    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_ra;
    logic [IDX_BITS-1:0]   mem_wa;
    logic [ENTRY_BITS-1:0] mem_wd;

    logic [CFG_BITS-1:0]   act_n;
    logic [CFG_BITS-1:0]   act_last;
    logic [CFG_BITS-1:0]   shown;
    logic [VALUE_BITS-1:0] rd_val;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  hit;
    logic [IDX_BITS-1:0]   new_slot;

    // Clamp the active slot count to 1..SLOTS
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            act_n = CFG_BITS'(1);
        end
        else if (cfg_reg > CFG_BITS'(SLOTS))
        begin
            act_n = CFG_BITS'(SLOTS);
        end
        else
        begin
            act_n = cfg_reg;
        end
        act_last = act_n - CFG_BITS'(1);
        shown    = (filled_reg < act_n) ? filled_reg : act_n;
    end

    // Entries never written read as zero
    assign rd_val   = rd_ok_reg ? rd_data_reg[ENTRY_BITS-1:COUNT_BITS] : '0;
    assign rd_cnt   = rd_ok_reg ? rd_data_reg[COUNT_BITS-1:0] : '0;
    assign hit      = chk_pend_reg && (rd_cnt != '0) && (rd_val == value_reg);
    assign new_slot = have_free_reg ? free_at_reg : chk_idx_reg;

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        cfg_next       = cfg_reg;
        value_next     = value_reg;
        last_idx_next  = last_idx_reg;
        ra_next        = ra_reg;
        issuing_next   = issuing_reg;
        chk_pend_next  = chk_pend_reg;
        chk_idx_next   = chk_idx_reg;
        have_free_next = have_free_reg;
        free_at_next   = free_at_reg;
        filled_next    = filled_reg;
        slot_ok_next   = slot_ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cand_next      = cand_reg;
        last_next      = last_reg;
        mem_re         = 1'b0;
        mem_ra         = ra_reg;
        mem_we         = 1'b0;
        mem_wa         = chk_idx_reg;
        mem_wd         = rd_data_reg;

        // Take a config word
        if (cfg_valid)
        begin
            cfg_next = slots_in_use;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    value_next     = item_value;
                    last_idx_next  = act_last[IDX_BITS-1:0];
                    ra_next        = '0;
                    issuing_next   = 1'b1;
                    chk_pend_next  = 1'b0;
                    have_free_next = 1'b0;
                    state_next     = (action == ACT_QUERY) ? S_QRD : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Advance the read pointer
                mem_re        = issuing_reg;
                chk_pend_next = issuing_reg;
                chk_idx_next  = ra_reg;
                if (issuing_reg)
                begin
                    if (ra_reg == last_idx_reg)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        ra_next = ra_reg + IDX_BITS'(1);
                    end
                end
                // Check the slot read last cycle
                if (hit)
                begin
                    mem_we = 1'b1;
                    mem_wd = {rd_val, (rd_cnt == COUNT_MAX) ? rd_cnt
                                                            : rd_cnt + COUNT_BITS'(1)};
                    issuing_next  = 1'b0;
                    chk_pend_next = 1'b0;
                    state_next    = S_IDLE;
                end
                else if (chk_pend_reg)
                begin
                    if ((rd_cnt == '0) && !have_free_reg)
                    begin
                        have_free_next = 1'b1;
                        free_at_next   = chk_idx_reg;
                    end
                    if (chk_idx_reg == last_idx_reg)
                    begin
                        issuing_next  = 1'b0;
                        chk_pend_next = 1'b0;
                        if (have_free_reg || (rd_cnt == '0))
                        begin
                            // Claim the lowest free slot
                            mem_we                 = 1'b1;
                            mem_wa                 = new_slot;
                            mem_wd                 = {value_reg, COUNT_BITS'(1)};
                            slot_ok_next[new_slot] = 1'b1;
                            if (CFG_BITS'(new_slot) + CFG_BITS'(1) > filled_reg)
                            begin
                                filled_next = CFG_BITS'(new_slot) + CFG_BITS'(1);
                            end
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            // No free slot: sweep and decrement
                            ra_next      = '0;
                            issuing_next = 1'b1;
                            state_next   = S_DEC;
                        end
                    end
                end
            end

            S_DEC:
            begin
                mem_re        = issuing_reg;
                chk_pend_next = issuing_reg;
                chk_idx_next  = ra_reg;
                if (issuing_reg)
                begin
                    if (ra_reg == last_idx_reg)
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        ra_next = ra_reg + IDX_BITS'(1);
                    end
                end
                // Drop each nonzero count by one
                if (chk_pend_reg)
                begin
                    if (rd_cnt != '0)
                    begin
                        mem_we = 1'b1;
                        mem_wd = {rd_val, rd_cnt - COUNT_BITS'(1)};
                    end
                    if (chk_idx_reg == last_idx_reg)
                    begin
                        issuing_next  = 1'b0;
                        chk_pend_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
            end

            S_QRD:
            begin
                // Unfilled slots repeat slot 0
                mem_re     = 1'b1;
                mem_ra     = (CFG_BITS'(ra_reg) < shown) ? ra_reg : '0;
                state_next = S_QOUT;
            end

            S_QOUT:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    cand_next      = rd_val;
                    last_next      = (ra_reg == last_idx_reg);
                    if (ra_reg == last_idx_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ra_next    = ra_reg + IDX_BITS'(1);
                        state_next = S_QRD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rd_ok_next = mem_re ? slot_ok_reg[mem_ra] : rd_ok_reg;
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_reg       <= SLOTS_IN_USE_RESET;
            issuing_reg   <= 1'b0;
            chk_pend_reg  <= 1'b0;
            have_free_reg <= 1'b0;
            filled_reg    <= '0;
            slot_ok_reg   <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            last_idx_reg  <= '0;
            ra_reg        <= '0;
            chk_idx_reg   <= '0;
            free_at_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            issuing_reg   <= issuing_next;
            chk_pend_reg  <= chk_pend_next;
            have_free_reg <= have_free_next;
            filled_reg    <= filled_next;
            slot_ok_reg   <= slot_ok_next;
            rd_ok_reg     <= rd_ok_next;
            out_valid_reg <= out_valid_next;
            last_idx_reg  <= last_idx_next;
            ra_reg        <= ra_next;
            chk_idx_reg   <= chk_idx_next;
            free_at_reg   <= free_at_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        cand_reg  <= cand_next;
        last_reg  <= last_next;
    end

    // Slot memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign candidate = cand_reg;
    assign last      = last_reg;

endmodule
